/* rtl/aacq_pkg.sv */
// aacq_pkg: shared types and constants of the area average cell luma quantizer.
// Used by aacq_frame_store, aacq_divider and the top level.
package aacq_pkg;

    localparam int MAX_WIDTH   = 256;
    localparam int MAX_HEIGHT  = 256;
    localparam int MAX_GRID    = 256;
    localparam int MAX_RAMP    = 1024;
    localparam int ADDR_W      = 16;
    localparam int PIX_W       = 24;
    localparam int NUM_W       = 28;
    localparam int DEN_W       = 18;
    localparam int CNT_W       = 5;
    // ceil(2^46 / 255000): exact floor division by 255000 for 28-bit numerators
    localparam int LUMA_SHIFT  = 46;
    localparam logic [28:0] LUMA_RECIP = 29'd275955860;

    typedef enum logic [2:0] {
        REG_FRAME_WIDTH  = 3'd0,
        REG_FRAME_HEIGHT = 3'd1,
        REG_GRID_COLS    = 3'd2,
        REG_GRID_ROWS    = 3'd3,
        REG_RAMP_LENGTH  = 3'd4
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_RAMP = 2'd1,
        ST_BAD_SIZE = 2'd2,
        ST_OUTSIDE  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        DIV_PX0 = 3'd0,
        DIV_PX1 = 3'd1,
        DIV_PY0 = 3'd2,
        DIV_PY1 = 3'd3,
        DIV_RED = 3'd4,
        DIV_GRN = 3'd5,
        DIV_BLU = 3'd6
    } div_sel_t;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [NUM_W-1:0] quot;
    } div_rsp_t;

endpackage

/* rtl/aacq_frame_store.sv */
// aacq_frame_store: 64K x 24 pixel memory, one write and one registered read port.
// Depends on aacq_pkg.
module aacq_frame_store
    import aacq_pkg::*;
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [PIX_W-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [PIX_W-1:0]  rd_data
);

    logic [PIX_W-1:0] mem [0:(1<<ADDR_W)-1];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

/* rtl/aacq_divider.sv */
// aacq_divider: restoring divider, one quotient bit per cycle.
// Depends on aacq_pkg (div_req_t, div_rsp_t).
module aacq_divider
    import aacq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic             busy_reg, busy_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic             done_reg, done_next;
    logic [DEN_W:0]   trial;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[NUM_W-1]};
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(NUM_W - 1);
            rem_next  = '0;
            quo_next  = req.num;
            den_next  = req.den;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = DEN_W'(trial - {1'b0, den_reg});
                quo_next = {quo_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DEN_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quo_reg;

endmodule

/* rtl/area_average_cell_luma_quantizer.sv */
// Area average cell luma quantizer, top level: sequencer, pixel walk, result register.
// Depends on aacq_pkg, aacq_frame_store and aacq_divider.
//
// A pixel write (tuser 0) is stored in the frame store. A cell request (tuser 1)
// finds its bounding box with four divisions, walks the box reading the frame store
// one address a cycle, drains the walk pipeline, divides the three sums and scales
// the luma: seven divisions on one shared divider in all. Error requests skip the
// divisions and the walk. The block takes no word while a cell is in progress; a
// finished result waits in the output register while the next word is taken.
module area_average_cell_luma_quantizer
    import aacq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [10:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic        s_tuser,   // opcode
    // pixel_x, pixel_y, pixel_red, pixel_green, pixel_blue, cell_col, cell_row
    input  logic [55:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // status, ramp_index, avg_red, avg_green, avg_blue, out_col, out_row, 4 zero bits
    output logic [55:0] m_tdata
);

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_DSTART = 10'b0000000010,
        S_DWAIT  = 10'b0000000100,
        S_PREP   = 10'b0000001000,
        S_WALK   = 10'b0000010000,
        S_DRAIN  = 10'b0000100000,
        S_LUMA   = 10'b0001000000,
        S_PROD   = 10'b0010000000,
        S_SCALE  = 10'b0100000000,
        S_DONE   = 10'b1000000000
    } state_t;

    // configuration
    logic [8:0]  width_reg, height_reg, cols_reg, rows_reg;
    logic [10:0] ramp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 9'd256;
            height_reg <= 9'd256;
            cols_reg   <= 9'd80;
            rows_reg   <= 9'd60;
            ramp_reg   <= 11'd10;
        end
        else if (cfg_we)
        begin
            case (reg_idx_t'(cfg_addr))
                REG_FRAME_WIDTH:  width_reg  <= cfg_wdata[8:0];
                REG_FRAME_HEIGHT: height_reg <= cfg_wdata[8:0];
                REG_GRID_COLS:    cols_reg   <= cfg_wdata[8:0];
                REG_GRID_ROWS:    rows_reg   <= cfg_wdata[8:0];
                REG_RAMP_LENGTH:  ramp_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // input fields
    logic [7:0] in_x, in_y, in_r, in_g, in_b, in_col, in_row;
    assign in_x   = s_tdata[7:0];
    assign in_y   = s_tdata[15:8];
    assign in_r   = s_tdata[23:16];
    assign in_g   = s_tdata[31:24];
    assign in_b   = s_tdata[39:32];
    assign in_col = s_tdata[47:40];
    assign in_row = s_tdata[55:48];

    state_t state_reg, state_next;
    div_sel_t sel_reg, sel_next;
    logic out_valid_reg, out_valid_next;

    logic [1:0]  status_reg, status_next;
    logic [7:0]  col_reg, col_next, row_reg, row_next;
    logic [16:0] xs_reg, xs_next, xe_reg, xe_next, ys_reg, ys_next, ye_reg, ye_next;
    logic [8:0]  px0_reg, px0_next, px1_reg, px1_next, py0_reg, py0_next, py1_reg, py1_next;
    logic [17:0] px0c_reg, px0c_next, pxc_reg, pxc_next, pyr_reg, pyr_next;
    logic [16:0] total_reg, total_next;
    logic [8:0]  px_reg, px_next, py_reg, py_next;
    logic [23:0] sr_reg, sr_next, sg_reg, sg_next, sb_reg, sb_next;
    logic [7:0]  ar_reg, ar_next, ag_reg, ag_next, ab_reg, ab_next;
    logic [17:0] luma_reg, luma_next;
    logic [27:0] prod_reg, prod_next;
    logic [9:0]  idx_reg, idx_next;

    // pipeline of the walk
    logic        v1_reg, v1_next, v2_reg;
    logic [8:0]  wx1_reg, wx1_next, wy1_reg, wy1_next;
    logic [17:0] w2_reg;
    logic [23:0] pix2_reg;

    logic accept;
    logic [1:0] chk_status;

    div_req_t dreq;
    div_rsp_t drsp;

    logic [23:0] rd_data;
    logic        st_we;

    logic [17:0] lo_x, hi_x, lo_y, hi_y;
    logic [8:0]  wx_c, wy_c;
    logic [7:0]  q_sat;
    logic [10:0] ramp_m1;
    logic [56:0] scaled;
    logic [10:0] scaled_q;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign st_we    = accept && !s_tuser;
    assign ramp_m1  = ramp_reg - 11'd1;

    aacq_frame_store u_store (
        .clk     (clk),
        .wr_en   (st_we),
        .wr_addr ({in_y, in_x}),
        .wr_data ({in_r, in_g, in_b}),
        .rd_addr ({py_reg[7:0], px_reg[7:0]}),
        .rd_data (rd_data)
    );

    aacq_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    always_comb
    begin
        if (ramp_reg < 11'd2 || ramp_reg > 11'(MAX_RAMP))
            chk_status = ST_BAD_RAMP;
        else if (width_reg == '0 || height_reg == '0 || cols_reg == '0 || rows_reg == '0
                 || width_reg > 9'(MAX_WIDTH) || height_reg > 9'(MAX_HEIGHT)
                 || cols_reg > 9'(MAX_GRID) || rows_reg > 9'(MAX_GRID))
            chk_status = ST_BAD_SIZE;
        else if ({1'b0, in_col} >= cols_reg || {1'b0, in_row} >= rows_reg)
            chk_status = ST_OUTSIDE;
        else
            chk_status = ST_OK;
    end

    // overlap weights of the pixel being issued
    always_comb
    begin
        lo_x = (pxc_reg > {1'b0, xs_reg}) ? pxc_reg : {1'b0, xs_reg};
        hi_x = (pxc_reg + {9'd0, cols_reg} < {1'b0, xe_reg})
               ? pxc_reg + {9'd0, cols_reg} : {1'b0, xe_reg};
        wx_c = (hi_x > lo_x) ? 9'(hi_x - lo_x) : 9'd0;
        lo_y = (pyr_reg > {1'b0, ys_reg}) ? pyr_reg : {1'b0, ys_reg};
        hi_y = (pyr_reg + {9'd0, rows_reg} < {1'b0, ye_reg})
               ? pyr_reg + {9'd0, rows_reg} : {1'b0, ye_reg};
        wy_c = (hi_y > lo_y) ? 9'(hi_y - lo_y) : 9'd0;
        q_sat = (drsp.quot > 28'd255) ? 8'd255 : drsp.quot[7:0];
        // divide by the luma full scale through a reciprocal multiply
        scaled   = 57'(prod_reg) * 57'(LUMA_RECIP);
        scaled_q = scaled[56:LUMA_SHIFT];
    end

    // divider operand selection
    always_comb
    begin
        dreq.start = (state_reg == S_DSTART);
        dreq.num   = '0;
        dreq.den   = {9'd0, cols_reg};
        case (sel_reg)
            DIV_PX0: dreq.num = {11'd0, xs_reg};
            DIV_PX1: dreq.num = 28'(xe_reg) + 28'(cols_reg) - 28'd1;
            DIV_PY0:
            begin
                dreq.num = {11'd0, ys_reg};
                dreq.den = {9'd0, rows_reg};
            end
            DIV_PY1:
            begin
                dreq.num = 28'(ye_reg) + 28'(rows_reg) - 28'd1;
                dreq.den = {9'd0, rows_reg};
            end
            DIV_RED:
            begin
                dreq.num = {4'd0, sr_reg};
                dreq.den = {1'b0, total_reg};
            end
            DIV_GRN:
            begin
                dreq.num = {4'd0, sg_reg};
                dreq.den = {1'b0, total_reg};
            end
            DIV_BLU:
            begin
                dreq.num = {4'd0, sb_reg};
                dreq.den = {1'b0, total_reg};
            end
            default: ;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        sel_next       = sel_reg;
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        col_next = col_reg;   row_next = row_reg;
        xs_next = xs_reg;     xe_next = xe_reg;
        ys_next = ys_reg;     ye_next = ye_reg;
        px0_next = px0_reg;   px1_next = px1_reg;
        py0_next = py0_reg;   py1_next = py1_reg;
        px0c_next = px0c_reg; pxc_next = pxc_reg; pyr_next = pyr_reg;
        total_next = total_reg;
        px_next = px_reg;     py_next = py_reg;
        sr_next = sr_reg;     sg_next = sg_reg;   sb_next = sb_reg;
        ar_next = ar_reg;     ag_next = ag_reg;   ab_next = ab_reg;
        luma_next = luma_reg; prod_next = prod_reg; idx_next = idx_reg;
        v1_next = 1'b0;
        wx1_next = wx_c;
        wy1_next = wy_c;

        if (m_tready)
            out_valid_next = 1'b0;

        // accumulate the weighted pixel leaving the pipe
        if (v2_reg)
        begin
            sr_next = sr_reg + 24'(pix2_reg[23:16] * w2_reg);
            sg_next = sg_reg + 24'(pix2_reg[15:8] * w2_reg);
            sb_next = sb_reg + 24'(pix2_reg[7:0] * w2_reg);
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept && s_tuser)
                begin
                    col_next    = in_col;
                    row_next    = in_row;
                    status_next = chk_status;
                    xs_next     = 17'(in_col * width_reg);
                    xe_next     = 17'(in_col * width_reg) + 17'(width_reg);
                    ys_next     = 17'(in_row * height_reg);
                    ye_next     = 17'(in_row * height_reg) + 17'(height_reg);
                    sr_next = '0; sg_next = '0; sb_next = '0;
                    ar_next = '0; ag_next = '0; ab_next = '0;
                    idx_next = '0;
                    sel_next = DIV_PX0;
                    state_next = (chk_status == ST_OK) ? S_DSTART : S_DONE;
                end
            end
            S_DSTART:
                state_next = S_DWAIT;
            S_DWAIT:
            begin
                if (drsp.done)
                begin
                    state_next = S_DSTART;
                    sel_next   = div_sel_t'(sel_reg + 3'd1);
                    case (sel_reg)
                        DIV_PX0: px0_next = drsp.quot[8:0];
                        DIV_PX1: px1_next = (drsp.quot > 28'(width_reg))
                                            ? width_reg : drsp.quot[8:0];
                        DIV_PY0: py0_next = drsp.quot[8:0];
                        DIV_PY1:
                        begin
                            py1_next = (drsp.quot > 28'(height_reg))
                                       ? height_reg : drsp.quot[8:0];
                            state_next = S_PREP;
                        end
                        DIV_RED: ar_next = q_sat;
                        DIV_GRN: ag_next = q_sat;
                        DIV_BLU:
                        begin
                            ab_next = q_sat;
                            sel_next = DIV_PX0;
                            state_next = S_LUMA;
                        end
                        default: ;
                    endcase
                end
            end
            S_PREP:
            begin
                px0c_next  = 18'(px0_reg * cols_reg);
                pxc_next   = 18'(px0_reg * cols_reg);
                pyr_next   = 18'(py0_reg * rows_reg);
                total_next = 17'(width_reg * height_reg);
                px_next    = px0_reg;
                py_next    = py0_reg;
                state_next = S_WALK;
            end
            S_WALK:
            begin
                v1_next = 1'b1;
                if (px_reg + 9'd1 == px1_reg)
                begin
                    px_next  = px0_reg;
                    pxc_next = px0c_reg;
                    py_next  = py_reg + 9'd1;
                    pyr_next = pyr_reg + {9'd0, rows_reg};
                    if (py_reg + 9'd1 == py1_reg)
                        state_next = S_DRAIN;
                end
                else
                begin
                    px_next  = px_reg + 9'd1;
                    pxc_next = pxc_reg + {9'd0, cols_reg};
                end
            end
            S_DRAIN:
            begin
                if (!v1_reg && !v2_reg)
                    state_next = S_DSTART;
            end
            S_LUMA:
            begin
                luma_next = 18'(ar_reg * 9'd299) + 18'(ag_reg * 10'd587)
                          + 18'(ab_reg * 7'd114);
                state_next = S_PROD;
            end
            S_PROD:
            begin
                prod_next  = 28'(luma_reg * ramp_m1[9:0]);
                state_next = S_SCALE;
            end
            S_SCALE:
            begin
                idx_next   = (scaled_q >= ramp_reg) ? ramp_m1[9:0] : scaled_q[9:0];
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sel_reg       <= DIV_PX0;
            out_valid_reg <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sel_reg       <= sel_next;
            out_valid_reg <= out_valid_next;
            v1_reg        <= v1_next;
            v2_reg        <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        col_reg <= col_next;     row_reg <= row_next;
        xs_reg <= xs_next;       xe_reg <= xe_next;
        ys_reg <= ys_next;       ye_reg <= ye_next;
        px0_reg <= px0_next;     px1_reg <= px1_next;
        py0_reg <= py0_next;     py1_reg <= py1_next;
        px0c_reg <= px0c_next;   pxc_reg <= pxc_next;   pyr_reg <= pyr_next;
        total_reg <= total_next;
        px_reg <= px_next;       py_reg <= py_next;
        sr_reg <= sr_next;       sg_reg <= sg_next;     sb_reg <= sb_next;
        ar_reg <= ar_next;       ag_reg <= ag_next;     ab_reg <= ab_next;
        luma_reg <= luma_next;   prod_reg <= prod_next; idx_reg <= idx_next;
        wx1_reg <= wx1_next;     wy1_reg <= wy1_next;
        w2_reg   <= 18'(wx1_reg * wy1_reg);
        pix2_reg <= rd_data;
    end

    // result register, loaded when the cell finishes
    logic [55:0] out_data_reg;

    always_ff @(posedge clk)
    begin
        if (state_reg == S_DONE && (!out_valid_reg || m_tready))
        begin
            out_data_reg <= {4'd0, row_reg, col_reg, ab_reg, ag_reg, ar_reg,
                             idx_reg, status_reg};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // error words carry zero averages and index
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[1:0] != ST_OK) |-> (m_tdata[35:2] == '0))
        else $error("error word with nonzero payload");

    // a good word never points past the ramp
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[1:0] == ST_OK) |-> ({1'b0, m_tdata[11:2]} < ramp_reg))
        else $error("ramp index out of range");

    // the divider is only started once its previous result came back
    a_div_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DWAIT) |=> (state_reg == S_DWAIT || $past(drsp.done)))
        else $error("left divider wait without a result");

endmodule

/* bench/testbench.sv */
// Self-checking bench for area_average_cell_luma_quantizer: pixel writes and cell requests
// driven over the stream ports, results checked against an in-bench area-average model.
// Depends on aacq_pkg and the top level only.
module testbench;
    import aacq_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_addr = '0;
    logic [10:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic        s_tuser = 1'b0;   // opcode
    // pixel_x, pixel_y, pixel_red, pixel_green, pixel_blue, cell_col, cell_row
    logic [55:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // status, ramp_index, avg_red, avg_green, avg_blue, out_col, out_row, 4 zero bits
    logic [55:0] m_tdata;

    typedef struct packed {
        logic [1:0] status;
        logic [9:0] idx;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] col;
        logic [7:0] row;
    } cell_result_t;

    typedef struct {
        logic        op;
        logic [55:0] data;
        logic        typed;
        cell_result_t want;
    } stim_row_t;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_CELL  = 1'b1;

    area_average_cell_luma_quantizer i_dut (.*);

    always #10 clk = ~clk;

    logic [23:0]  pixels [0:65535];
    bit           written [0:65535];
    int unsigned  fw, fh, gc, gr, rl;
    cell_result_t pending_cells [$];
    int           errors = 0;
    int           cells_seen = 0;
    int           pix_writes = 0;
    int           send_idle = 11;
    int           recv_idle = 47;
    bit           hold_recv = 1'b0;

    task automatic report(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    function automatic longint unsigned ovl(longint unsigned lo, longint unsigned hi,
                                            longint unsigned a, longint unsigned b);
        longint unsigned s, e;
        s = lo > a ? lo : a;
        e = hi < b ? hi : b;
        return e > s ? e - s : 0;
    endfunction

    function automatic cell_result_t average_cell(logic [7:0] col, logic [7:0] row);
        cell_result_t r;
        longint unsigned sr, sg, sb, xs, xe, ys, ye, px0, px1, py0, py1, w, tot, luma;
        longint unsigned ix;
        r = '0;
        r.col = col;
        r.row = row;
        if (rl < 2 || rl > MAX_RAMP) r.status = ST_BAD_RAMP;
        else if (fw == 0 || fh == 0 || gc == 0 || gr == 0 || fw > MAX_WIDTH ||
                 fh > MAX_HEIGHT || gc > MAX_GRID || gr > MAX_GRID)
            r.status = ST_BAD_SIZE;
        else if (col >= gc || row >= gr) r.status = ST_OUTSIDE;
        else begin
            r.status = ST_OK;
            sr = 0; sg = 0; sb = 0;
            xs = col * fw; xe = (col + 1) * fw;
            ys = row * fh; ye = (row + 1) * fh;
            px0 = xs / gc; px1 = (xe + gc - 1) / gc;
            py0 = ys / gr; py1 = (ye + gr - 1) / gr;
            if (px1 > fw) px1 = fw;
            if (py1 > fh) py1 = fh;
            for (longint unsigned py = py0; py < py1; py++)
                for (longint unsigned px = px0; px < px1; px++) begin
                    w = ovl(px * gc, (px + 1) * gc, xs, xe) *
                        ovl(py * gr, (py + 1) * gr, ys, ye);
                    sr += pixels[py * 256 + px][23:16] * w;
                    sg += pixels[py * 256 + px][15:8] * w;
                    sb += pixels[py * 256 + px][7:0] * w;
                end
            tot = fw * fh;
            sr /= tot; sg /= tot; sb /= tot;
            if (sr > 255) sr = 255;
            if (sg > 255) sg = 255;
            if (sb > 255) sb = 255;
            r.red = 8'(sr); r.green = 8'(sg); r.blue = 8'(sb);
            luma = 299 * sr + 587 * sg + 114 * sb;
            ix = luma * (rl - 1) / 255000;
            if (ix >= rl) ix = rl - 1;
            r.idx = 10'(ix);
        end
        return r;
    endfunction

    // true when every pixel the cell reads has been written
    function automatic bit cell_covered(logic [7:0] col, logic [7:0] row);
        int unsigned px0, px1, py0, py1;
        if (rl < 2 || rl > MAX_RAMP || fw == 0 || fh == 0 || gc == 0 || gr == 0 ||
            fw > MAX_WIDTH || fh > MAX_HEIGHT || gc > MAX_GRID || gr > MAX_GRID ||
            col >= gc || row >= gr)
            return 1'b1;
        px0 = col * fw / gc; px1 = ((col + 1) * fw + gc - 1) / gc;
        py0 = row * fh / gr; py1 = ((row + 1) * fh + gr - 1) / gr;
        if (px1 > fw) px1 = fw;
        if (py1 > fh) py1 = fh;
        for (int unsigned y = py0; y < py1; y++)
            for (int unsigned x = px0; x < px1; x++)
                if (!written[y * 256 + x]) return 1'b0;
        return 1'b1;
    endfunction

    function automatic logic [55:0] pix_word(int x, int y, logic [23:0] rgb);
        return {16'd0, rgb[7:0], rgb[15:8], rgb[23:16], 8'(y), 8'(x)};
    endfunction

    function automatic logic [55:0] cell_word(int col, int row);
        return {8'(row), 8'(col), 40'd0};
    endfunction

    task automatic send(input logic op, input logic [55:0] data,
                        input bit typed, input cell_result_t want);
        cell_result_t p;
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= data;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        if (op == OP_WRITE) begin
            pixels[{data[15:8], data[7:0]}] = {data[23:16], data[31:24], data[39:32]};
            written[{data[15:8], data[7:0]}] = 1'b1;
            pix_writes++;
        end else begin
            p = average_cell(data[47:40], data[55:48]);
            if (typed && p != want) report("typed row", int'(p), int'(want));
            pending_cells.push_back(typed ? want : p);
        end
    endtask

    task automatic set_reg(input reg_idx_t a, input int unsigned v);
        cfg_we    <= 1'b1;
        cfg_addr  <= a;
        cfg_wdata <= 11'(v);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (a)
            REG_FRAME_WIDTH:  fw = v & 9'h1FF;
            REG_FRAME_HEIGHT: fh = v & 9'h1FF;
            REG_GRID_COLS:    gc = v & 9'h1FF;
            REG_GRID_ROWS:    gr = v & 9'h1FF;
            default:          rl = v & 11'h7FF;
        endcase
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        while (pending_cells.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic fill_frame(input int w, input int h);
        for (int y = 0; y < h; y++)
            for (int x = 0; x < w; x++)
                send(OP_WRITE, pix_word(x, y, 24'($urandom)), 1'b0, '0);
    endtask

    // receiver
    always @(posedge clk) begin
        cell_result_t got, exp_r;
        if (m_tvalid && m_tready) begin
            got = m_tdata[55:4] ^ '0;
            got = {m_tdata[1:0], m_tdata[11:2], m_tdata[19:12], m_tdata[27:20],
                   m_tdata[35:28], m_tdata[43:36], m_tdata[51:44]};
            cells_seen++;
            if (pending_cells.size() == 0) report("unexpected result", int'(got.col), -1);
            else begin
                exp_r = pending_cells.pop_front();
                if (got.status != exp_r.status) report("status", got.status, exp_r.status);
                if (got.idx != exp_r.idx) report("ramp_index", got.idx, exp_r.idx);
                if (got.red != exp_r.red) report("avg_red", got.red, exp_r.red);
                if (got.green != exp_r.green) report("avg_green", got.green, exp_r.green);
                if (got.blue != exp_r.blue) report("avg_blue", got.blue, exp_r.blue);
                if (got.col != exp_r.col) report("out_col", got.col, exp_r.col);
                if (got.row != exp_r.row) report("out_row", got.row, exp_r.row);
            end
        end
        m_tready <= !hold_recv && ($urandom_range(99) >= recv_idle);
    end

    initial begin
        #20_000_000;
        $display("FAILURE");
        $finish;
    end

    initial begin
        stim_row_t rows [$];
        stim_row_t t;
        int unsigned c, r, n;
        for (int i = 0; i < 65536; i++) written[i] = 1'b0;
        fw = 256; fh = 256; gc = 80; gr = 60; rl = 10;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset config: errors and grid edge echoes without reading the store
        t = '{OP_CELL, cell_word(80, 0), 1'b1, '{ST_OUTSIDE, 0, 0, 0, 0, 80, 0}};
        rows.push_back(t);
        t = '{OP_CELL, cell_word(0, 60), 1'b1, '{ST_OUTSIDE, 0, 0, 0, 0, 0, 60}};
        rows.push_back(t);
        t = '{OP_CELL, cell_word(255, 255), 1'b1, '{ST_OUTSIDE, 0, 0, 0, 0, 255, 255}};
        rows.push_back(t);
        // extreme pixels, then the other pixels of the 2x2 frame
        t = '{OP_WRITE, pix_word(0, 0, 24'hFFFFFF), 1'b0, '0}; rows.push_back(t);
        t = '{OP_WRITE, pix_word(255, 255, 24'h000000), 1'b0, '0}; rows.push_back(t);
        t = '{OP_WRITE, pix_word(1, 0, 24'hFF0000), 1'b0, '0}; rows.push_back(t);
        t = '{OP_WRITE, pix_word(0, 1, 24'h00FF00), 1'b0, '0}; rows.push_back(t);
        t = '{OP_WRITE, pix_word(1, 1, 24'h0000FF), 1'b0, '0}; rows.push_back(t);
        foreach (rows[i]) send(rows[i].op, rows[i].data, rows[i].typed, rows[i].want);
        drain();

        // 2x2 frame, one cell: mean of the four pixels
        set_reg(REG_FRAME_WIDTH, 2);
        set_reg(REG_FRAME_HEIGHT, 2);
        set_reg(REG_GRID_COLS, 1);
        set_reg(REG_GRID_ROWS, 1);
        set_reg(REG_RAMP_LENGTH, 1024);
        send(OP_CELL, cell_word(0, 0), 1'b0, '0);
        drain();
        set_reg(REG_RAMP_LENGTH, 2);
        send(OP_CELL, cell_word(0, 0), 1'b0, '0);
        drain();
        set_reg(REG_RAMP_LENGTH, 1);
        send(OP_CELL, cell_word(0, 0), 1'b1, '{ST_BAD_RAMP, 0, 0, 0, 0, 0, 0});
        drain();
        set_reg(REG_RAMP_LENGTH, 1025);
        send(OP_CELL, cell_word(3, 4), 1'b1, '{ST_BAD_RAMP, 0, 0, 0, 0, 3, 4});
        drain();
        set_reg(REG_RAMP_LENGTH, 2047);
        send(OP_CELL, cell_word(0, 0), 1'b1, '{ST_BAD_RAMP, 0, 0, 0, 0, 0, 0});
        drain();
        set_reg(REG_RAMP_LENGTH, 10);
        set_reg(REG_FRAME_WIDTH, 0);
        send(OP_CELL, cell_word(0, 0), 1'b1, '{ST_BAD_SIZE, 0, 0, 0, 0, 0, 0});
        drain();
        set_reg(REG_FRAME_WIDTH, 257);
        send(OP_CELL, cell_word(0, 0), 1'b1, '{ST_BAD_SIZE, 0, 0, 0, 0, 0, 0});
        drain();
        set_reg(REG_FRAME_WIDTH, 511);
        set_reg(REG_GRID_ROWS, 0);
        send(OP_CELL, cell_word(0, 0), 1'b1, '{ST_BAD_SIZE, 0, 0, 0, 0, 0, 0});
        drain();
        set_reg(REG_FRAME_WIDTH, 2);
        set_reg(REG_GRID_ROWS, 257);
        send(OP_CELL, cell_word(0, 0), 1'b1, '{ST_BAD_SIZE, 0, 0, 0, 0, 0, 0});
        drain();
        set_reg(REG_GRID_ROWS, 1);
        set_reg(REG_FRAME_HEIGHT, 0);
        send(OP_CELL, cell_word(0, 0), 1'b1, '{ST_BAD_SIZE, 0, 0, 0, 0, 0, 0});
        drain();
        set_reg(REG_FRAME_HEIGHT, 2);
        set_reg(REG_GRID_COLS, 300);
        send(OP_CELL, cell_word(0, 0), 1'b1, '{ST_BAD_SIZE, 0, 0, 0, 0, 0, 0});
        drain();

        // random phases: small frames and one full-size frame, random grids and ramps, three idling modes
        for (int phase = 0; phase < 12; phase++) begin
            if (phase == 4) begin send_idle = 47; recv_idle = 11; end
            if (phase == 8) begin send_idle = 0; recv_idle = 0; end
            set_reg(REG_FRAME_WIDTH, (phase == 11) ? 256 : $urandom_range(1, 8));
            set_reg(REG_FRAME_HEIGHT, (phase == 11) ? 256 : $urandom_range(1, 8));
            set_reg(REG_GRID_COLS, (phase == 11) ? 256 : $urandom_range(1, 14));
            set_reg(REG_GRID_ROWS, (phase == 11) ? 256 : $urandom_range(1, 14));
            set_reg(REG_RAMP_LENGTH, (phase % 3 == 0) ? 1024 : $urandom_range(2, 40));
            if (phase != 11) fill_frame(fw, fh);
            else begin
                // large frame: only two 2x2 corner blocks are written, at the origin and the far corner
                fill_frame(2, 2);
                for (int y = 254; y < 256; y++)
                    for (int x = 254; x < 256; x++)
                        send(OP_WRITE, pix_word(x, y, 24'($urandom)), 1'b0, '0);
            end
            if (phase == 9) begin
                fork
                    begin
                        hold_recv = 1'b1;
                        repeat (2000) @(posedge clk);
                        hold_recv = 1'b0;
                    end
                join_none
            end
            n = 0;
            while (n < 25) begin
                if (phase == 11) begin
                    c = $urandom_range(1) ? 255 : 0;
                    r = $urandom_range(1) ? 255 : 0;
                end else begin
                    c = ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(gc - 1);
                    r = ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(gr - 1);
                end
                if ($urandom_range(4) == 0 && phase != 11)
                    send(OP_WRITE, pix_word($urandom_range(fw - 1), $urandom_range(fh - 1),
                         24'($urandom)), 1'b0, '0);
                else if (cell_covered(8'(c), 8'(r)))
                    send(OP_CELL, cell_word(c, r), 1'b0, '0);
                n++;
            end
            drain();
        end

        $display("covered %0d pixel writes and %0d cell results", pix_writes, cells_seen);
        $display("across error, small-frame and full-size configurations");
        if (errors == 0 && pending_cells.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
